### src/cqs_pkg.sv
`default_nettype none

package cqs_pkg;

  localparam int unsigned DEPTH_DEFAULT = 8;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CODE_W   = 32;
  localparam int unsigned WEIGHT_W = 32;
  localparam int unsigned SLOT_W   = CODE_W + WEIGHT_W;

  typedef logic [MODE_W-1:0]        mode_t;
  typedef logic [STATUS_W-1:0]      status_t;
  typedef logic signed [CODE_W-1:0] code_t;
  typedef logic [WEIGHT_W-1:0]      weight_t;

  localparam mode_t MODE_INSERT = 2'd0;
  localparam mode_t MODE_REMOVE = 2'd1;
  localparam mode_t MODE_PEEK   = 2'd2;
  localparam mode_t MODE_SEARCH = 2'd3;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_FULL    = 2'd1;
  localparam status_t ST_EMPTY   = 2'd2;
  localparam status_t ST_MISSING = 2'd3;

endpackage

`default_nettype wire

### src/cqs_if.sv
`default_nettype none

interface cqs_req_if;
  import cqs_pkg::*;

  logic    valid;
  logic    ready;
  mode_t   mode;
  code_t   item_code;
  weight_t item_weight;

  modport source (output valid, output mode, output item_code, output item_weight,
                  input ready);
  modport sink (input valid, input mode, input item_code, input item_weight,
                output ready);
endinterface

interface cqs_rsp_if;
  import cqs_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  code_t   out_code;
  weight_t out_weight;
  logic    is_empty;
  logic    is_full;

  modport source (output valid, output status, output out_code, output out_weight,
                  output is_empty, output is_full, input ready);
  modport sink (input valid, input status, input out_code, input out_weight,
                input is_empty, input is_full, output ready);
endinterface

`default_nettype wire

### src/circular_queue_with_search.sv
// Circular queue of DEPTH slots holding up to DEPTH-1 entries of a signed code
// and a 32-bit weight word, with insert, remove, peek and search by code.
// Requests arrive on req (valid/ready); each request gives exactly one result on
// rsp (valid/ready): a status, the entry data, and empty and full flags.
// One request is worked at a time: req.ready is high only while the sequencer
// is idle. Insert, and any request on an empty queue, goes from the idle state
// straight to S_FIN; remove and peek first pass through S_RD to take the
// registered memory read; a search walks S_SCAN from the front entry until a
// hit or past the last held entry, then goes to S_FIN. The scan compares one
// slot per cycle through the single read port of the slot memory.
// Results sit in an output register, so a new request is taken while an
// earlier result waits; if the receiver stalls, the next result is held in the
// sequencer and req.ready stays low until the output register frees up.
// Synchronous reset empties the queue and drops any pending result; slot
// contents are not cleared, as only data from occupied slots is ever used.
`default_nettype none

module circular_queue_with_search #(
  parameter int unsigned DEPTH = cqs_pkg::DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  cqs_req_if.sink   req,
  cqs_rsp_if.source rsp
);
  import cqs_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
    return (p == LAST) ? '0 : p + 1'b1;
  endfunction

  logic [1:0]        state;
  logic [AW-1:0]     head;
  logic [AW-1:0]     tail;
  logic [AW-1:0]     scan_ptr;
  logic [AW-1:0]     rd_addr;
  logic [SLOT_W-1:0] mem [DEPTH];
  logic [SLOT_W-1:0] rd_data;
  logic              pend;
  code_t             key;
  status_t           res_status;
  code_t             res_code;
  weight_t           res_weight;

  logic              out_valid;
  status_t           out_status;
  code_t             out_code;
  weight_t           out_weight;
  logic              out_empty;
  logic              out_full;

  logic              q_empty;
  logic              q_full;
  logic              accept;
  logic              mem_we;
  logic              hit;
  logic              rsp_free;

  assign q_empty  = (head == tail);
  assign q_full   = (nxt(tail) == head);
  assign req.ready = (state == S_IDLE);
  assign accept   = req.valid && req.ready;
  assign mem_we   = accept && (req.mode == MODE_INSERT) && !q_full;
  assign rd_addr  = (state == S_SCAN) ? scan_ptr : head;
  assign hit      = (rd_data[CODE_W-1:0] == $unsigned(key));
  assign rsp_free = !out_valid || rsp.ready;

  // Slot memory: one write port at the tail, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail] <= {req.item_weight, $unsigned(req.item_code)};
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_FIN) && rsp_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            key        <= req.item_code;
            res_status <= ST_OK;
            res_code   <= '0;
            res_weight <= '0;
            state      <= S_FIN;
            if (req.mode == MODE_INSERT) begin
              if (q_full) begin
                res_status <= ST_FULL;
              end else begin
                tail <= nxt(tail);
              end
            end else if (q_empty) begin
              res_status <= ST_EMPTY;
            end else begin
              case (req.mode)
                MODE_REMOVE: begin
                  head  <= nxt(head);
                  state <= S_RD;
                end
                MODE_PEEK: begin
                  state <= S_RD;
                end
                default: begin
                  // The front slot is read at this edge; the scan continues behind it.
                  scan_ptr <= nxt(head);
                  pend     <= 1'b1;
                  state    <= S_SCAN;
                end
              endcase
            end
          end
        end
        S_RD: begin
          res_code   <= $signed(rd_data[CODE_W-1:0]);
          res_weight <= rd_data[SLOT_W-1:CODE_W];
          state      <= S_FIN;
        end
        S_SCAN: begin
          // pend marks that rd_data holds an occupied slot to compare this cycle.
          if (pend && hit) begin
            res_code   <= $signed(rd_data[CODE_W-1:0]);
            res_weight <= rd_data[SLOT_W-1:CODE_W];
            state      <= S_FIN;
          end else if (!pend) begin
            res_status <= ST_MISSING;
            state      <= S_FIN;
          end else begin
            pend     <= (scan_ptr != tail);
            scan_ptr <= nxt(scan_ptr);
          end
        end
        S_FIN: begin
          if (rsp_free) begin
            out_status <= res_status;
            out_code   <= res_code;
            out_weight <= res_weight;
            out_empty  <= q_empty;
            out_full   <= q_full;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.out_code   = out_code;
  assign rsp.out_weight = out_weight;
  assign rsp.is_empty   = out_empty;
  assign rsp.is_full    = out_full;

endmodule

`default_nettype wire

### src/cqs_checker.sv
`default_nettype none

module cqs_checker (
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input cqs_pkg::status_t status,
  input cqs_pkg::code_t   out_code,
  input cqs_pkg::weight_t out_weight,
  input logic             is_empty,
  input logic             is_full
);
  import cqs_pkg::*;

  // A result that is not taken stays offered.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result withdrawn before its transfer");

  // Only one request is worked at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is being worked");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(is_empty && is_full))
    else $error("queue reported both empty and full");

  a_status_flags: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_FULL) |-> is_full)
    else $error("full status without full flag");

  a_no_data_on_fail: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_EMPTY || status == ST_MISSING)
      |-> (out_code == '0) && (out_weight == '0) && (status == ST_MISSING || is_empty))
    else $error("failed request carried data or inconsistent empty flag");

endmodule

bind circular_queue_with_search cqs_checker u_cqs_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .status     (rsp.status),
  .out_code   (rsp.out_code),
  .out_weight (rsp.out_weight),
  .is_empty   (rsp.is_empty),
  .is_full    (rsp.is_full)
);

`default_nettype wire

### bench/tb_circular_queue_with_search.sv
`default_nettype none

module tb_circular_queue_with_search;
  timeunit 1ns;
  timeprecision 1ps;

  import cqs_pkg::*;

  localparam int QDEPTH      = 8;
  localparam int HOLD_LEN    = 300;
  localparam int IDLE_LIMIT  = 4000;
  localparam int SETTLE_CYC  = QDEPTH + 6;
  localparam code_t CODE_MIN = 32'sh8000_0000;
  localparam code_t CODE_MAX = 32'sh7fff_ffff;

  typedef struct {
    status_t status;
    code_t   out_code;
    weight_t out_weight;
    logic    is_empty;
    logic    is_full;
  } queue_result_t;

  logic clk = 1'b0;
  logic rst;

  cqs_req_if req_ch ();
  cqs_rsp_if rsp_ch ();

  circular_queue_with_search #(.DEPTH(QDEPTH)) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the queue, advanced once per accepted request.
  code_t        shadow_code [QDEPTH];
  weight_t      shadow_weight [QDEPTH];
  logic [2:0]   shadow_head;
  logic [2:0]   shadow_tail;

  queue_result_t pending_results[$];

  int err_count;
  int sent_items;
  int checked_results;
  int n_insert, n_remove, n_peek, n_search;
  int n_full_reject, n_empty_hit, n_search_hit, n_search_miss;

  // Sender pacing.
  int burst_left;
  bit steady;

  // Receiver stall pattern and long hold-off requests.
  int hold_asked;
  int hold_served;
  int hold_count;
  int stall_mode;
  int stall_left;
  int stall_phase;

  int idle_cycles;

  function automatic logic [2:0] next_slot(logic [2:0] i);
    return (int'(i) == QDEPTH - 1) ? 3'd0 : i + 3'd1;
  endfunction

  function automatic int held_entries();
    return (int'(shadow_tail) - int'(shadow_head) + QDEPTH) % QDEPTH;
  endfunction

  function automatic void clear_shadow();
    shadow_head = '0;
    shadow_tail = '0;
    for (int i = 0; i < QDEPTH; i++) begin
      shadow_code[i]   = '0;
      shadow_weight[i] = '0;
    end
  endfunction

  function automatic queue_result_t apply_request(mode_t m, code_t c, weight_t w);
    queue_result_t r;
    logic [2:0]    idx;
    r.status     = ST_OK;
    r.out_code   = '0;
    r.out_weight = '0;
    if (m == MODE_INSERT) begin
      n_insert++;
      if (next_slot(shadow_tail) == shadow_head) begin
        r.status = ST_FULL;
        n_full_reject++;
      end else begin
        shadow_code[shadow_tail]   = c;
        shadow_weight[shadow_tail] = w;
        shadow_tail = next_slot(shadow_tail);
      end
    end else begin
      if (m == MODE_REMOVE) n_remove++;
      else if (m == MODE_PEEK) n_peek++;
      else n_search++;
      if (shadow_head == shadow_tail) begin
        r.status = ST_EMPTY;
        n_empty_hit++;
      end else if (m == MODE_REMOVE) begin
        r.out_code   = shadow_code[shadow_head];
        r.out_weight = shadow_weight[shadow_head];
        shadow_head  = next_slot(shadow_head);
      end else if (m == MODE_PEEK) begin
        r.out_code   = shadow_code[shadow_head];
        r.out_weight = shadow_weight[shadow_head];
      end else begin
        r.status = ST_MISSING;
        idx = shadow_head;
        while (idx != shadow_tail && r.status == ST_MISSING) begin
          if (shadow_code[idx] == c) begin
            r.status     = ST_OK;
            r.out_code   = shadow_code[idx];
            r.out_weight = shadow_weight[idx];
          end
          idx = next_slot(idx);
        end
        if (r.status == ST_OK) n_search_hit++;
        else n_search_miss++;
      end
    end
    r.is_empty = (shadow_head == shadow_tail);
    r.is_full  = (next_slot(shadow_tail) == shadow_head);
    return r;
  endfunction

  // Codes lean on a small pool so that duplicates and search hits are common.
  function automatic code_t rand_code();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return CODE_MIN;
      1: return CODE_MAX;
      2: return '0;
      3: return -1;
      4, 5, 6: return code_t'($urandom_range(0, 5)) - 2;
      default: return code_t'($urandom);
    endcase
  endfunction

  // Mostly a code that is currently held, otherwise anything.
  function automatic code_t search_key();
    int         cnt;
    logic [2:0] idx;
    cnt = held_entries();
    if (cnt != 0 && $urandom_range(0, 3) != 0) begin
      idx = shadow_head + 3'($urandom_range(0, cnt - 1));
      return shadow_code[idx];
    end
    return rand_code();
  endfunction

  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready)
      pending_results.push_back(apply_request(req_ch.mode, req_ch.item_code,
                                              req_ch.item_weight));
  end

  always @(posedge clk) begin
    queue_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: status %0d code %0d",
               rsp_ch.status, rsp_ch.out_code);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        checked_results++;
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d actual %0d", want.status, rsp_ch.status);
          err_count++;
        end
        if (rsp_ch.out_code !== want.out_code) begin
          $error("out_code: expected %0d actual %0d", want.out_code, rsp_ch.out_code);
          err_count++;
        end
        if (rsp_ch.out_weight !== want.out_weight) begin
          $error("out_weight: expected %h actual %h", want.out_weight, rsp_ch.out_weight);
          err_count++;
        end
        if (rsp_ch.is_empty !== want.is_empty) begin
          $error("is_empty: expected %b actual %b", want.is_empty, rsp_ch.is_empty);
          err_count++;
        end
        if (rsp_ch.is_full !== want.is_full) begin
          $error("is_full: expected %b actual %b", want.is_full, rsp_ch.is_full);
          err_count++;
        end
      end
    end
  end

  // Receiver: a long hold-off when one is asked for, otherwise a stall pattern
  // that switches at random among four modes.
  always @(negedge clk) begin
    if (hold_count > 0) begin
      hold_count--;
      rsp_ch.ready <= 1'b0;
    end else if (hold_asked != hold_served) begin
      hold_served++;
      hold_count = HOLD_LEN - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(8, 80);
      end
      stall_left--;
      stall_phase++;
      case (stall_mode)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= 1'($urandom_range(0, 1));
        2: rsp_ch.ready <= ($urandom_range(0, 4) != 0);
        default: rsp_ch.ready <= (stall_phase % 5 >= 2);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("tb_circular_queue_with_search: done, errors");
      $finish;
    end
  end

  task automatic idle_for(int n);
    repeat (n) begin
      @(negedge clk);
      req_ch.valid       <= 1'b0;
      req_ch.mode        <= mode_t'($urandom);
      req_ch.item_code   <= code_t'($urandom);
      req_ch.item_weight <= weight_t'($urandom);
    end
  endtask

  // Offers one request and returns at the edge where its transfer happens.
  task automatic send_request(mode_t m, code_t c, weight_t w);
    if (!steady) begin
      if (burst_left == 0) begin
        idle_for($urandom_range(1, 8));
        burst_left = $urandom_range(1, 16);
      end
      burst_left--;
    end
    @(negedge clk);
    req_ch.valid       <= 1'b1;
    req_ch.mode        <= m;
    req_ch.item_code   <= c;
    req_ch.item_weight <= w;
    do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
    sent_items++;
  endtask

  task automatic send_random(int insert_pct);
    int    r;
    mode_t m;
    code_t c;
    r = $urandom_range(0, 99);
    if (r < insert_pct) m = MODE_INSERT;
    else m = mode_t'($urandom_range(1, 3));
    c = (m == MODE_SEARCH) ? search_key() : rand_code();
    send_request(m, c, weight_t'($urandom));
  endtask

  task automatic wait_drained();
    idle_for(1);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic test_directed();
    code_t   codes [7];
    weight_t weights [7];
    codes   = '{CODE_MIN, CODE_MAX, 0, -1, 5, CODE_MAX, 17};
    weights = '{32'h0000_0000, 32'hffff_ffff, 32'ha5a5_a5a5, 32'h5a5a_5a5a,
                32'h0000_0001, 32'h8000_0000, 32'h7fff_ffff};
    // Requests on the empty queue right after reset.
    send_request(MODE_REMOVE, 0, 0);
    send_request(MODE_PEEK, 0, 0);
    send_request(MODE_SEARCH, 5, 0);
    for (int i = 0; i < 7; i++) send_request(MODE_INSERT, codes[i], weights[i]);
    send_request(MODE_INSERT, 3, 32'hdead_beef);
    send_request(MODE_SEARCH, CODE_MIN, 0);
    send_request(MODE_SEARCH, 17, 0);
    // The maximum code is held twice; the front one must be found.
    send_request(MODE_SEARCH, CODE_MAX, 0);
    send_request(MODE_SEARCH, 12345, 0);
    send_request(MODE_PEEK, 0, 0);
    for (int i = 0; i < 7; i++) send_request(MODE_REMOVE, 0, 0);
    send_request(MODE_REMOVE, 0, 0);
    wait_drained();
  endtask

  task automatic test_random_mix(int n);
    int insert_pct;
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 0) begin
        case ($urandom_range(0, 3))
          0: insert_pct = 80;
          1: insert_pct = 20;
          default: insert_pct = 50;
        endcase
        steady = ($urandom_range(0, 3) == 0);
      end
      send_random(insert_pct);
    end
    steady = 1'b0;
  endtask

  task automatic test_backpressure();
    // The receiver holds off while requests keep coming without gaps,
    // so the result path fills and the request side must stall.
    steady = 1'b1;
    hold_asked++;
    for (int i = 0; i < 40; i++) send_random(60);
    steady = 1'b0;
    wait_drained();
  endtask

  task automatic test_drain_pause();
    for (int round = 0; round < 5; round++) begin
      for (int i = 0; i < 12; i++) send_random(55);
      wait_drained();
    end
  endtask

  initial begin
    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.mode        = MODE_INSERT;
    req_ch.item_code   = '0;
    req_ch.item_weight = '0;
    rsp_ch.ready       = 1'b0;
    err_count = 0;
    sent_items = 0;
    checked_results = 0;
    n_insert = 0; n_remove = 0; n_peek = 0; n_search = 0;
    n_full_reject = 0; n_empty_hit = 0; n_search_hit = 0; n_search_miss = 0;
    burst_left = 0;
    steady = 1'b0;
    hold_asked = 0;
    hold_served = 0;
    hold_count = 0;
    stall_mode = 0;
    stall_left = 0;
    stall_phase = 0;
    idle_cycles = 0;
    clear_shadow();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_mix(800);
    test_backpressure();
    test_drain_pause();
    test_random_mix(700);
    wait_drained();

    $display("covered %0d requests: %0d insert, %0d remove, %0d peek, %0d search",
             sent_items, n_insert, n_remove, n_peek, n_search);
    $display("  %0d checked, %0d full rejects, %0d empty, %0d search hits, %0d misses",
             checked_results, n_full_reject, n_empty_hit, n_search_hit, n_search_miss);
    if (err_count == 0)
      $display("tb_circular_queue_with_search: done, clean");
    else
      $display("tb_circular_queue_with_search: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
